>>> design/serial_frame_deframer_crc8_core_assert.svh
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SERIAL_FRAME_DEFRAMER_CRC8_CORE_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_CRC8_CORE_ASSERT_SVH

// Property that must hold in the same cycle whenever the condition is true.
`define SFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after the condition is true.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sfd_pkg.sv
// Shared types, constants and the CRC-8 step for the frame deframer.
// No dependencies; every module imports this package.
package sfd_pkg;

    // Fixed field widths of the result item.
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 7;
    localparam int IDX_W        = 6;
    // Address width that covers the largest frame store (64 + 4 entries).
    localparam int STORE_ADDR_W = 7;

    // Frame layout: id, len, payload, crc.
    localparam int FRAME_OVERHEAD = 3;
    localparam int MIN_STORED     = 3;
    localparam int PAYLOAD_BASE   = 2;
    localparam int ID_POS         = 0;
    localparam int LEN_POS        = 1;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HEAD  = 2'd0,
        REG_TAIL  = 2'd1,
        REG_POLY  = 2'd2,
        REG_START = 2'd3
    } sfd_reg_t;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] HEAD_RESET  = 8'h00;
    localparam logic [BYTE_W-1:0] TAIL_RESET  = 8'h00;
    localparam logic [BYTE_W-1:0] POLY_RESET  = 8'h07;
    localparam logic [BYTE_W-1:0] START_RESET = 8'h00;

    // Configuration values seen by the front.
    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] tail;
        logic [BYTE_W-1:0] poly;
        logic [BYTE_W-1:0] start;
    } sfd_cfg_t;

    // Command kinds passed from the front to the back.
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_EMIT  = 1'b1
    } sfd_op_t;

    typedef struct packed {
        sfd_op_t                 op;
        logic [BYTE_W-1:0]       data;
        logic [STORE_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]       id;
        logic [LEN_W-1:0]        len;
    } sfd_cmd_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_PUT,
        B_EMPTY
    } sfd_bstate_t;

    // One byte through an MSB-first, unreflected CRC-8 with no final XOR.
    function automatic logic [BYTE_W-1:0] crc8_feed(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1])
            begin
                c = (c << 1) ^ poly;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/sfd_front.sv
// Front of the deframer: tracks framing, running CRC and frame checks.
// Depends on sfd_pkg; issues store and emit commands to the queue.
`include "serial_frame_deframer_crc8_core_assert.svh"

module sfd_front
    import sfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfd_cfg_t              cfg,
    input  logic                  in_valid,
    input  logic [BYTE_W-1:0]     in_byte,
    output logic                  q_push,
    output sfd_cmd_t              q_cmd,
    input  logic                  q_full
);

    localparam int DEPTH = MAX_PAYLOAD + 4;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              synced_reg, synced_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] crc_thru_reg, crc_thru_next;
    logic [BYTE_W-1:0] crc_before_reg, crc_before_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [BYTE_W-1:0] last_reg, last_next;

    logic is_head, is_tail_end, has_room, frame_ok;

    // Classify the incoming item against the current framing state.
    assign is_head     = (in_byte == cfg.head);
    assign is_tail_end = (in_byte == cfg.tail) && (count_reg >= CNT_W'(MIN_STORED));
    assign has_room    = (count_reg < CNT_W'(DEPTH));
    assign frame_ok    = ((BYTE_W + 1)'(count_reg) == ({1'b0, len_reg} + 9'(FRAME_OVERHEAD)))
                         && (len_reg <= BYTE_W'(MAX_PAYLOAD))
                         && (crc_before_reg == last_reg);

    // Next framing state and the command that goes to the back.
    always_comb
    begin
        synced_next     = synced_reg;
        count_next      = count_reg;
        crc_thru_next   = crc_thru_reg;
        crc_before_next = crc_before_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        last_next       = last_reg;
        q_push          = 1'b0;
        q_cmd.op        = CMD_STORE;
        q_cmd.data      = in_byte;
        q_cmd.addr      = STORE_ADDR_W'(count_reg);
        q_cmd.id        = id_reg;
        q_cmd.len       = len_reg[LEN_W-1:0];
        if (in_valid)
        begin
            if (!synced_reg)
            begin
                // Hunt for the head byte; everything else is dropped.
                if (is_head)
                begin
                    synced_next     = 1'b1;
                    count_next      = '0;
                    crc_thru_next   = cfg.start;
                    crc_before_next = cfg.start;
                end
            end
            else if (is_tail_end)
            begin
                // End of frame: hand a good frame to the back, drop a bad one.
                synced_next = 1'b0;
                if (frame_ok)
                begin
                    q_push   = 1'b1;
                    q_cmd.op = CMD_EMIT;
                end
            end
            else if (has_room)
            begin
                // Ordinary frame byte: store it and advance the CRC.
                q_push          = 1'b1;
                count_next      = count_reg + CNT_W'(1);
                crc_before_next = crc_thru_reg;
                crc_thru_next   = crc8_feed(crc_thru_reg, in_byte, cfg.poly);
                last_next       = in_byte;
                if (count_reg == CNT_W'(ID_POS))
                begin
                    id_next = in_byte;
                end
                if (count_reg == CNT_W'(LEN_POS))
                begin
                    len_next = in_byte;
                end
            end
            else
            begin
                // Store overflow abandons the frame.
                synced_next = 1'b0;
            end
        end
    end

    // Framing control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg     <= 1'b0;
            count_reg      <= '0;
            crc_thru_reg   <= START_RESET;
            crc_before_reg <= START_RESET;
        end
        else
        begin
            synced_reg     <= synced_next;
            count_reg      <= count_next;
            crc_thru_reg   <= crc_thru_next;
            crc_before_reg <= crc_before_next;
        end
    end

    // Captured header fields and the most recent stored byte.
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

    `SFD_ASSERT_IMPL(a_front_push_room, q_push, !q_full,
        "front pushed a command into a full queue")
    `SFD_ASSERT_NEXT(a_front_emit_unsync, q_push && (q_cmd.op == CMD_EMIT), !synced_reg,
        "front stayed in a frame after handing it off")

endmodule

>>> design/sfd_queue.sv
// Short command queue between the deframer front and back.
// Depends on sfd_pkg for the command type and depth.
`include "serial_frame_deframer_crc8_core_assert.svh"

module sfd_queue
    import sfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sfd_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output sfd_cmd_t pop_cmd,
    output logic     empty
);

    sfd_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    // Status and guarded handshakes.
    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SFD_ASSERT_NEXT(a_queue_grow, push && !full && !(pop && !empty),
        cnt_reg == $past(cnt_reg) + QCNT_W'(1), "queue occupancy did not grow on push")

endmodule

>>> design/sfd_back.sv
// Back of the deframer: frame store memory and the result sequencer.
// Depends on sfd_pkg; consumes commands from the queue.
`include "serial_frame_deframer_crc8_core_assert.svh"

module sfd_back
    import sfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfd_cmd_t          q_cmd,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_pop,
    output logic [BYTE_W-1:0] out_id,
    output logic [LEN_W-1:0]  out_len,
    output logic [IDX_W-1:0]  out_idx,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_has,
    output logic              out_last
);

    localparam int DEPTH  = MAX_PAYLOAD + 4;
    localparam int ADDR_W = $clog2(DEPTH);

    sfd_bstate_t       state_reg, state_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_id_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_has_reg;
    logic              out_last_reg;

    logic slot_free, at_last, out_load;

    assign slot_free = !out_valid_reg || out_pop;
    assign at_last   = ((LEN_W)'(k_reg) + LEN_W'(1)) == len_reg;
    assign rd_addr   = ADDR_W'(k_reg) + ADDR_W'(PAYLOAD_BASE);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && (q_cmd.op == CMD_EMIT))
                begin
                    state_next = (q_cmd.len == '0) ? B_EMPTY : B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_PUT;
            end
            B_PUT:
            begin
                if (slot_free)
                begin
                    state_next = at_last ? B_IDLE : B_READ;
                end
            end
            B_EMPTY:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer outputs and working registers.
    always_comb
    begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        mem_we   = q_pop && (q_cmd.op == CMD_STORE);
        out_load = slot_free && ((state_reg == B_PUT) || (state_reg == B_EMPTY));
        id_next  = id_reg;
        len_next = len_reg;
        k_next   = k_reg;
        if (q_pop && (q_cmd.op == CMD_EMIT))
        begin
            id_next  = q_cmd.id;
            len_next = q_cmd.len;
            k_next   = '0;
        end
        else if ((state_reg == B_PUT) && slot_free)
        begin
            k_next = k_reg + IDX_W'(1);
        end
        out_valid_next = out_load ? 1'b1 : (out_pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Frame header of the frame being emitted.
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        len_reg <= len_next;
    end

    // Frame store: one write port from the queue, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_cmd.addr[ADDR_W-1:0]] <= q_cmd.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Output register holding the oldest waiting result.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_id_reg  <= id_reg;
            out_len_reg <= len_reg;
            if (state_reg == B_PUT)
            begin
                out_idx_reg  <= k_reg;
                out_byte_reg <= rd_data_reg;
                out_has_reg  <= 1'b1;
                out_last_reg <= at_last;
            end
            else
            begin
                out_idx_reg  <= '0;
                out_byte_reg <= '0;
                out_has_reg  <= 1'b0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_len   = out_len_reg;
    assign out_idx   = out_idx_reg;
    assign out_byte  = out_byte_reg;
    assign out_has   = out_has_reg;
    assign out_last  = out_last_reg;

    `SFD_ASSERT_IMPL(a_back_empty_last, out_valid_reg && !out_has_reg,
        out_last_reg && (out_byte_reg == '0), "empty-payload result not marked last")
    `SFD_ASSERT_NEXT(a_back_idle_after_last, out_load && (state_reg == B_PUT) && at_last,
        state_reg == B_IDLE, "sequencer kept running after the last payload byte")

endmodule

>>> design/serial_frame_deframer_crc8_core.sv
// Top level of the head/tail framed byte-stream deframer with CRC-8 check.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
// Usage: received bytes enter on rx_byte and are taken when push is high and
// full is low. A frame is head, id, len, payload, crc, tail; the CRC-8
// (MSB-first, configurable polynomial and start value) covers id, len and
// payload. Good frames produce one result per payload byte, or a single
// result with has_data low for an empty payload; last marks the final one.
// Bad, short, oversized or overflowing frames vanish without a result.
// Results wait on the output ports while empty is low and leave on pop.
// Throughput: the front takes one byte per cycle while the command queue
// has room. The back fetches each payload byte from the frame store in
// B_READ (a registered read), puts it out in B_PUT, and pops no commands
// while a frame drains, so full can rise meanwhile. After the tail byte
// is taken, the emit command goes through the queue before the back acts.
// If the receiver stops popping, a result waits in the output register,
// then the queue fills and full holds off new bytes; nothing is lost.
// Reset returns to hunting for the head byte, empties the queue and loads
// the register defaults (polynomial 0x07, others zero); the frame store
// needs no clearing. Registers sit at byte addresses 0, 4, 8, 12.
module serial_frame_deframer_crc8_core
    import sfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input channel
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] rx_byte,
    // Result channel
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] frame_id,
    output logic [LEN_W-1:0]  payload_length,
    output logic [IDX_W-1:0]  payload_index,
    output logic [BYTE_W-1:0] payload_byte,
    output logic              has_data,
    output logic              last
);

    sfd_cfg_t          cfg_reg;
    logic              cfg_we;
    sfd_reg_t          cfg_sel;

    logic              q_push, q_full, q_pop, q_empty;
    sfd_cmd_t          q_in_cmd, q_out_cmd;
    logic              out_valid;

    // Configuration register file.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = sfd_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head  <= HEAD_RESET;
            cfg_reg.tail  <= TAIL_RESET;
            cfg_reg.poly  <= POLY_RESET;
            cfg_reg.start <= START_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_HEAD:  cfg_reg.head  <= pwdata[BYTE_W-1:0];
                REG_TAIL:  cfg_reg.tail  <= pwdata[BYTE_W-1:0];
                REG_POLY:  cfg_reg.poly  <= pwdata[BYTE_W-1:0];
                REG_START: cfg_reg.start <= pwdata[BYTE_W-1:0];
                default:   cfg_reg.head  <= cfg_reg.head;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_sel)
            REG_HEAD:  prdata = 32'(cfg_reg.head);
            REG_TAIL:  prdata = 32'(cfg_reg.tail);
            REG_POLY:  prdata = 32'(cfg_reg.poly);
            REG_START: prdata = 32'(cfg_reg.start);
            default:   prdata = '0;
        endcase
    end

    // Input acceptance is gated by the command queue.
    assign full = q_full;

    sfd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (push && !q_full),
        .in_byte  (rx_byte),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd),
        .q_full   (q_full)
    );

    sfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_out_cmd),
        .empty    (q_empty)
    );

    sfd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (q_out_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_pop   (pop),
        .out_id    (frame_id),
        .out_len   (payload_length),
        .out_idx   (payload_index),
        .out_byte  (payload_byte),
        .out_has   (has_data),
        .out_last  (last)
    );

    assign empty = !out_valid;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for serial_frame_deframer_crc8_core: framed byte streams in,
// payload results out. A scoreboard class predicts the results and checks them.
// Depends on sfd_pkg and the deframer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfd_pkg::*;

    localparam int MAX_LEN     = 64;
    localparam int STORE_DEPTH = MAX_LEN + 4;
    localparam int MIN_STORED  = 3;
    localparam int FRAME_EXTRA = 3;
    localparam int ID_AT       = 0;
    localparam int LEN_AT      = 1;
    localparam int DATA_AT     = 2;
    localparam int SETTLE      = 16;
    localparam int PHASE_BYTES = 64;
    localparam int LIMIT_NS    = 5_000_000;

    typedef bit [7:0] octet_t;

    typedef struct packed {
        logic [BYTE_W-1:0] id;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
        logic              has_data;
        logic              last;
    } frame_result_t;

    // Tracks the deframer state byte by byte and holds the payload results still due.
    class frame_tracker;
        octet_t head = HEAD_RESET;
        octet_t tail = TAIL_RESET;
        octet_t poly = POLY_RESET;
        octet_t start = START_RESET;
        bit locked;
        int stored;
        octet_t store [STORE_DEPTH];
        octet_t crc_all = START_RESET;
        octet_t crc_prev = START_RESET;
        frame_result_t expected_results[$];
        int errors;
        int framed_bytes;

        function void set_reg(sfd_reg_t r, octet_t v);
            case (r)
                REG_HEAD:  head = v;
                REG_TAIL:  tail = v;
                REG_POLY:  poly = v;
                REG_START: start = v;
                default: ;
            endcase
        endfunction

        // Bit-serial CRC-8, MSB first, no reflection and no final XOR.
        function octet_t crc_step(octet_t c, octet_t b);
            bit fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[7] ^ b[i];
                c = c << 1;
                if (fb)
                    c ^= poly;
            end
            return c;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Advances the state by one accepted byte and queues any results it releases.
        function void take_byte(octet_t b);
            int len;
            frame_result_t r;
            if (!locked)
            begin
                if (b == head)
                begin
                    locked = 1'b1;
                    stored = 0;
                    crc_all = start;
                    crc_prev = start;
                    framed_bytes++;
                end
                return;
            end
            framed_bytes++;
            // A tail only closes the frame once id, length and one more byte are in.
            if (b == tail && stored >= MIN_STORED)
            begin
                locked = 1'b0;
                len = store[LEN_AT];
                if (stored != len + FRAME_EXTRA || len > MAX_LEN)
                    return;
                if (crc_prev != store[stored - 1])
                    return;
                if (len == 0)
                begin
                    r = '{id: store[ID_AT], len: '0, idx: '0, data: '0,
                          has_data: 1'b0, last: 1'b1};
                    expected_results.push_back(r);
                end
                for (int k = 0; k < len; k++)
                begin
                    r.id = store[ID_AT];
                    r.len = LEN_W'(len);
                    r.idx = IDX_W'(k);
                    r.data = store[DATA_AT + k];
                    r.has_data = 1'b1;
                    r.last = (k == len - 1);
                    expected_results.push_back(r);
                end
                return;
            end
            // A byte arriving at a full store abandons the frame.
            if (stored < STORE_DEPTH)
            begin
                store[stored] = b;
                stored++;
                crc_prev = crc_all;
                crc_all = crc_step(crc_all, b);
            end
            else
                locked = 1'b0;
        endfunction

        function void check_field(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h got %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no item pending, frame_id %0h payload_index %0d",
                         $time, got.id, got.idx);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            check_field("frame_id", want.id, got.id);
            check_field("payload_length", want.len, got.len);
            check_field("payload_index", want.idx, got.idx);
            check_field("payload_byte", want.data, got.data);
            check_field("has_data", want.has_data, got.has_data);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    bit clk;
    bit rst_n;
    bit psel;
    bit penable;
    bit pwrite;
    bit [3:0] paddr;
    bit [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    bit push;
    logic full;
    bit [BYTE_W-1:0] rx_byte;
    logic empty;
    bit pop;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0] payload_length;
    logic [IDX_W-1:0] payload_index;
    logic [BYTE_W-1:0] payload_byte;
    logic has_data;
    logic last;

    int tx_idle;
    int rx_idle;
    octet_t tx_bytes[$];
    octet_t payload_buf[$];
    frame_tracker tracker = new();

    serial_frame_deframer_crc8_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("tb_top failed");
        $finish;
    end

    // The receiver stalls at random according to the current idle percentage.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= rx_idle);

    // Every popped result is checked against the oldest prediction.
    always @(posedge clk)
        if (rst_n && pop && !empty)
            tracker.check_result({frame_id, payload_length, payload_index, payload_byte,
                                  has_data, last});

    // Presents one byte and holds it until the block takes it; entered and left at a falling edge.
    task automatic send_byte(input octet_t b);
        while ($urandom_range(99) < tx_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.take_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (tx_bytes[i])
            send_byte(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    // Stops sending and waits until every predicted result has been popped.
    task automatic wait_idle();
        push <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_xfer(input bit wr, input sfd_reg_t r, input bit [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {r, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr)
            tracker.set_reg(r, wdata[7:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Writes a register with random upper data bits, then reads it back.
    task automatic write_reg(input sfd_reg_t r, input octet_t v);
        bit [31:0] word;
        logic [31:0] back;
        word = $urandom;
        word[7:0] = v;
        apb_xfer(1'b1, r, word, back);
        apb_xfer(1'b0, r, '0, back);
        if (back[7:0] !== v)
        begin
            $display("%0t: register %s read expected %0h got %0h", $time, r.name(), v,
                     back[7:0]);
            tracker.errors++;
        end
    endtask

    task automatic set_config(input octet_t h, input octet_t t, input octet_t p, input octet_t s);
        write_reg(REG_HEAD, h);
        write_reg(REG_TAIL, t);
        write_reg(REG_POLY, p);
        write_reg(REG_START, s);
    endtask

    function automatic octet_t frame_crc(octet_t id, octet_t len_field);
        octet_t c;
        c = tracker.crc_step(tracker.start, id);
        c = tracker.crc_step(c, len_field);
        foreach (payload_buf[i])
            c = tracker.crc_step(c, payload_buf[i]);
        return c;
    endfunction

    // Random payload; bytes past the first never equal the tail so the frame is not cut short.
    function automatic void fill_payload(int n);
        octet_t b;
        payload_buf.delete();
        for (int k = 0; k < n; k++)
        begin
            b = octet_t'($urandom);
            if (k > 0 && b == tracker.tail)
                b ^= 8'h01;
            payload_buf.push_back(b);
        end
    endfunction

    function automatic void build_frame(octet_t id, octet_t len_field, bit crc_ok);
        octet_t c;
        c = frame_crc(id, len_field);
        if (!crc_ok)
            c ^= octet_t'($urandom_range(1, 255));
        tx_bytes.push_back(tracker.head);
        tx_bytes.push_back(id);
        tx_bytes.push_back(len_field);
        foreach (payload_buf[i])
            tx_bytes.push_back(payload_buf[i]);
        tx_bytes.push_back(c);
        tx_bytes.push_back(tracker.tail);
    endfunction

    // A well-formed frame; for a non-empty payload the id is nudged until the CRC byte differs from the tail.
    task automatic good_frame(input int n);
        octet_t id;
        fill_payload(n);
        id = octet_t'($urandom);
        while (n > 0 && frame_crc(id, octet_t'(n)) == tracker.tail)
            id++;
        build_frame(id, octet_t'(n), 1'b1);
        send_frame();
    endtask

    // Head, a full store of non-tail bytes, then one more byte that gets dropped.
    task automatic overflow_frame(input octet_t closing);
        octet_t b;
        tx_bytes.push_back(tracker.head);
        repeat (STORE_DEPTH)
        begin
            b = octet_t'($urandom);
            if (b == tracker.tail)
                b ^= 8'h01;
            tx_bytes.push_back(b);
        end
        tx_bytes.push_back(closing);
        send_frame();
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return $urandom_range(0, 6);
        if (r < 97)
            return $urandom_range(7, 63);
        return MAX_LEN;
    endfunction

    // Mostly good frames with random content, plus damaged frames and line noise.
    task automatic random_phase(input int tx_pct, input int rx_pct, input bit hold_once);
        int first;
        int frames;
        int r;
        int n;
        octet_t len_field;
        tx_idle = tx_pct;
        rx_idle = rx_pct;
        first = tracker.framed_bytes;
        frames = 0;
        while (tracker.framed_bytes - first < PHASE_BYTES)
        begin
            r = $urandom_range(99);
            n = pick_len();
            if (r < 70)
                good_frame(n);
            else if (r < 78)
            begin
                fill_payload(n);
                build_frame(octet_t'($urandom), octet_t'(n), 1'b0);
                send_frame();
            end
            else if (r < 85)
            begin
                fill_payload(n);
                if (n > 0 && $urandom_range(1))
                    len_field = octet_t'(n - 1);
                else
                    len_field = octet_t'(n + $urandom_range(1, 3));
                build_frame(octet_t'($urandom), len_field, 1'b1);
                send_frame();
            end
            else if (r < 90)
            begin
                fill_payload($urandom_range(0, 8));
                build_frame(octet_t'($urandom), octet_t'($urandom), $urandom_range(1));
                send_frame();
            end
            else if (r < 97)
                repeat ($urandom_range(1, 6)) send_byte(octet_t'($urandom));
            else if (r < 99)
            begin
                fill_payload(n + 2);
                payload_buf[1] = tracker.tail;
                build_frame(octet_t'($urandom), octet_t'(n + 2), 1'b1);
                send_frame();
            end
            else
                overflow_frame(octet_t'($urandom));
            frames++;
            if (hold_once && frames == 2)
                wait_idle();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: head and tail are both zero, so a zero length is stored as data.
        send_byte(8'h11);
        send_byte(8'h22);
        good_frame(0);
        good_frame(3);
        wait_idle();

        set_config(8'hA5, 8'h5A, 8'h31, 8'hFF);
        // Largest id with a single zero payload byte.
        payload_buf = '{8'h00};
        build_frame(8'hFF, 8'd1, 1'b1);
        send_frame();
        // Longest payload with alternating extreme bytes.
        payload_buf.delete();
        for (int k = 0; k < MAX_LEN; k++)
            payload_buf.push_back(k[0] ? 8'hFF : 8'h00);
        build_frame(8'h00, 8'(MAX_LEN), 1'b1);
        send_frame();
        // One byte over the payload limit with a consistent byte count.
        fill_payload(MAX_LEN + 1);
        build_frame(8'h42, 8'(MAX_LEN + 1), 1'b1);
        send_frame();
        // Corrupted CRC.
        fill_payload(2);
        build_frame(8'h10, 8'd2, 1'b0);
        send_frame();
        // Length field claims more bytes than were sent.
        fill_payload(2);
        build_frame(8'h11, 8'd3, 1'b1);
        send_frame();
        // A tail inside the payload closes the frame early.
        fill_payload(4);
        payload_buf[1] = tracker.tail;
        build_frame(8'h12, 8'd4, 1'b1);
        send_frame();
        // Tail as id and as first payload byte, head bytes inside: all plain data.
        payload_buf = '{8'h5A, 8'hA5, 8'hA5};
        build_frame(8'h5A, 8'd3, 1'b1);
        send_frame();
        // Store overflow; the dropped byte is the head and must not resync.
        overflow_frame(8'hA5);
        good_frame(1);
        // Empty payload, good and with a bad CRC.
        good_frame(0);
        fill_payload(0);
        build_frame(8'h33, 8'd0, 1'b0);
        send_frame();
        wait_idle();

        set_config(8'h00, 8'hFF, 8'h00, 8'h00);
        random_phase(36, 62, 1'b1);
        wait_idle();
        set_config(8'hFF, 8'h00, 8'hFF, 8'hFF);
        random_phase(62, 36, 1'b0);
        wait_idle();
        set_config(octet_t'($urandom), octet_t'($urandom), octet_t'($urandom),
                   octet_t'($urandom));
        random_phase(0, 0, 1'b0);

        // Drain the remaining results and watch for strays.
        push <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/sfd_pkg.sv
design/sfd_front.sv
design/sfd_queue.sv
design/sfd_back.sv
design/serial_frame_deframer_crc8_core.sv
verif/tb_top.sv
